// ===== rtl/ecd_pkg.sv =====
`timescale 1ns / 1ps
// ecd_pkg: constants, field types, span tables and the microcode program
// of the epoch seconds to calendar date converter. No dependencies.
package ecd_pkg;

  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned SECS_PER_HOUR = 60 * 60;
  localparam int unsigned SECS_PER_DAY  = 24 * 60 * 60;
  localparam int unsigned BASE_YEAR     = 1970;
  // Only century year in 1970..2106 that is not a leap year; 2000 is one.
  localparam int unsigned NO_LEAP_CENTURY = 2100;

  typedef logic [31:0] secs_t;
  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  min_t;
  typedef logic [5:0]  sec_t;

  localparam month_t LAST_MONTH = month_t'(12);

  typedef enum logic [1:0] {
    COND_START,
    COND_GE,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [2:0] {
    SPAN_NONE,
    SPAN_YEAR,
    SPAN_MONTH,
    SPAN_DAY,
    SPAN_HOUR,
    SPAN_MIN
  } span_sel_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SUB,
    ACT_EMIT
  } act_t;

  localparam int unsigned PROG_LEN = 7;
  localparam int unsigned PC_W     = $clog2(PROG_LEN);
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t ST_WAIT  = pc_t'(0);
  localparam pc_t ST_YEAR  = pc_t'(1);
  localparam pc_t ST_MONTH = pc_t'(2);
  localparam pc_t ST_DAY   = pc_t'(3);
  localparam pc_t ST_HOUR  = pc_t'(4);
  localparam pc_t ST_MIN   = pc_t'(5);
  localparam pc_t ST_EMIT  = pc_t'(6);

  // On a true condition the action fires and pc jumps; otherwise pc holds
  // or advances.
  typedef struct packed {
    cond_t     cond;
    logic      hold;
    span_sel_t span;
    act_t      act;
    pc_t       jmp;
  } uword_t;

  localparam uword_t UCODE [PROG_LEN] = '{
    '{COND_START,    1'b1, SPAN_NONE,  ACT_LOAD, ST_YEAR},
    '{COND_GE,       1'b0, SPAN_YEAR,  ACT_SUB,  ST_YEAR},
    '{COND_GE,       1'b0, SPAN_MONTH, ACT_SUB,  ST_MONTH},
    '{COND_GE,       1'b0, SPAN_DAY,   ACT_SUB,  ST_DAY},
    '{COND_GE,       1'b0, SPAN_HOUR,  ACT_SUB,  ST_HOUR},
    '{COND_GE,       1'b0, SPAN_MIN,   ACT_SUB,  ST_MIN},
    '{COND_OUT_FREE, 1'b1, SPAN_NONE,  ACT_EMIT, ST_WAIT}
  };

  typedef struct packed {
    span_sel_t span;
    logic      load;
    logic      sub;
  } dp_cmd_t;

  typedef struct packed {
    logic ge;
  } dp_stat_t;

  // Valid for years 1970..2106 only.
  function automatic logic is_leap(year_t y);
    return (y[1:0] == 2'b00) && (y != year_t'(NO_LEAP_CENTURY));
  endfunction

  function automatic secs_t year_span(logic leap);
    return leap ? secs_t'(366 * SECS_PER_DAY) : secs_t'(365 * SECS_PER_DAY);
  endfunction

  function automatic secs_t month_span(month_t m, logic leap);
    secs_t s;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: s = secs_t'(30 * SECS_PER_DAY);
      4'd2:                    s = leap ? secs_t'(29 * SECS_PER_DAY)
                                        : secs_t'(28 * SECS_PER_DAY);
      default:                 s = secs_t'(31 * SECS_PER_DAY);
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ecd_if.sv =====
`timescale 1ns / 1ps
// ecd_in_if, ecd_out_if: valid/ready channels for the input seconds and
// the calendar result. Depends on ecd_pkg.
interface ecd_in_if import ecd_pkg::*; ;
  logic  valid;
  logic  ready;
  secs_t epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecd_out_if import ecd_pkg::*; ;
  logic   valid;
  logic   ready;
  year_t  year;
  month_t month;
  day_t   day;
  hour_t  hour;
  min_t   minute;
  sec_t   second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

// ===== rtl/epoch_seconds_to_calendar_date_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                   Transfer
// in_ch     in   epoch_seconds[31:0]                       valid && ready
// out_ch    out  year[11:0] month[3:0] day[4:0] hour[4:0]  valid && ready
//                minute[5:0] second[5:0]
// An item runs through the year, month, day, hour and minute loops in turn:
// the microcode loops on one 32-bit compare/subtract per cycle.
// One item is converted at a time; the next is taken while a result waits.
// Reset (rst_n, synchronous) returns the sequencer to its wait step and
// empties the output register. Output stall holds only the final step.
// Top level: microcode sequencer. Depends on ecd_pkg, ecd_if, ecd_datapath.
module epoch_seconds_to_calendar_date_top import ecd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ecd_in_if.sink    in_ch,
  ecd_out_if.source out_ch
);

  pc_t      pc_r, pc_nxt;
  uword_t   uw;
  logic     cond_true;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_valid_r, out_valid_nxt;
  logic     emit;

  year_t  dp_year;
  month_t dp_month;
  day_t   dp_day;
  hour_t  dp_hour;
  min_t   dp_minute;
  sec_t   dp_second;

  year_t  year_r;
  month_t month_r;
  day_t   day_r;
  hour_t  hour_r;
  min_t   minute_r;
  sec_t   second_r;

  assign uw = UCODE[pc_r];

  always_comb begin
    unique case (uw.cond)
      COND_START:    cond_true = in_ch.valid;
      COND_GE:       cond_true = stat.ge;
      COND_OUT_FREE: cond_true = !out_valid_r || out_ch.ready;
      default:       cond_true = 1'b0;
    endcase
  end

  assign in_ch.ready = (uw.cond == COND_START);

  assign cmd.span = uw.span;
  assign cmd.load = cond_true && (uw.act == ACT_LOAD);
  assign cmd.sub  = cond_true && (uw.act == ACT_SUB);
  assign emit     = cond_true && (uw.act == ACT_EMIT);

  always_comb begin
    if (cond_true) begin
      pc_nxt = uw.jmp;
    end else if (uw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + pc_t'(1);
    end
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      year_r   <= dp_year;
      month_r  <= dp_month;
      day_r    <= dp_day;
      hour_r   <= dp_hour;
      minute_r <= dp_minute;
      second_r <= dp_second;
    end
  end

  ecd_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .load_secs (in_ch.epoch_seconds),
    .stat      (stat),
    .year      (dp_year),
    .month     (dp_month),
    .day       (dp_day),
    .hour      (dp_hour),
    .minute    (dp_minute),
    .second    (dp_second)
  );

  assign out_ch.valid  = out_valid_r;
  assign out_ch.year   = year_r;
  assign out_ch.month  = month_r;
  assign out_ch.day    = day_r;
  assign out_ch.hour   = hour_r;
  assign out_ch.minute = minute_r;
  assign out_ch.second = second_r;

  a_accept_starts_year: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> pc_r == ST_YEAR)
    else $error("accepted item did not start the year loop");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_ch.valid)
    else $error("emitted result not presented");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= ST_EMIT)
    else $error("step counter left the program");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.month >= month_t'(1) && out_ch.month <= LAST_MONTH)
    else $error("month out of range");

  a_wait_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == ST_EMIT && out_valid_r && !out_ch.ready |=> pc_r == ST_EMIT)
    else $error("left final step while output stalled");

endmodule

// ===== rtl/ecd_datapath.sv =====
`timescale 1ns / 1ps
// ecd_datapath: remainder register, calendar counters and the shared
// 32-bit compare/subtract unit. Depends on ecd_pkg.
module ecd_datapath import ecd_pkg::*; (
  input  logic     clk,
  input  dp_cmd_t  cmd,
  input  secs_t    load_secs,
  output dp_stat_t stat,
  output year_t    year,
  output month_t   month,
  output day_t     day,
  output hour_t    hour,
  output min_t     minute,
  output sec_t     second
);

  secs_t  t_r,      t_nxt;
  year_t  year_r,   year_nxt;
  month_t month_r,  month_nxt;
  day_t   day_r,    day_nxt;
  hour_t  hour_r,   hour_nxt;
  min_t   minute_r, minute_nxt;
  secs_t  span;
  secs_t  diff;
  logic   leap;
  logic   ge;

  assign leap = is_leap(year_r);

  always_comb begin
    case (cmd.span)
      SPAN_YEAR:  span = year_span(leap);
      SPAN_MONTH: span = month_span(month_r, leap);
      SPAN_DAY:   span = secs_t'(SECS_PER_DAY);
      SPAN_HOUR:  span = secs_t'(SECS_PER_HOUR);
      SPAN_MIN:   span = secs_t'(SECS_PER_MIN);
      default:    span = '0;
    endcase
  end

  assign diff = t_r - span;
  assign ge   = (t_r >= span) &&
                !((cmd.span == SPAN_MONTH) && (month_r == LAST_MONTH));
  assign stat.ge = ge;

  always_comb begin
    t_nxt      = t_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    if (cmd.load) begin
      t_nxt      = load_secs;
      year_nxt   = year_t'(BASE_YEAR);
      month_nxt  = month_t'(1);
      day_nxt    = day_t'(1);
      hour_nxt   = '0;
      minute_nxt = '0;
    end else if (cmd.sub) begin
      t_nxt = diff;
      case (cmd.span)
        SPAN_YEAR:  year_nxt   = year_r + year_t'(1);
        SPAN_MONTH: month_nxt  = month_r + month_t'(1);
        SPAN_DAY:   day_nxt    = day_r + day_t'(1);
        SPAN_HOUR:  hour_nxt   = hour_r + hour_t'(1);
        SPAN_MIN:   minute_nxt = minute_r + min_t'(1);
        default:    t_nxt      = t_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    day_r    <= day_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
  end

  assign year   = year_r;
  assign month  = month_r;
  assign day    = day_r;
  assign hour   = hour_r;
  assign minute = minute_r;
  assign second = t_r[5:0];

endmodule
